[design/tmmf_pkg.sv]
package tmmf_pkg;

    // Default widths of one sample and of the high-pass state.
    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int HIGHPASS_WIDTH_DEF = 20;

    // Filter coefficients, given as right-shift amounts.
    localparam int LOWPASS_SHIFT  = 2;
    localparam int HIGHPASS_SHIFT = 3;

    // Result width and lane count.
    localparam int MAG_WIDTH = 16;
    localparam int NUM_AXES  = 3;

endpackage

[design/tmmf_lane.sv]
module tmmf_lane
    import tmmf_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int HIGHPASS_WIDTH = HIGHPASS_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_sample,
    output logic        [HIGHPASS_WIDTH-1:0] o_abs
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int HW = HIGHPASS_WIDTH;
    // Working width of the high-pass update before the clamp.
    localparam int AW = ((HW > SW + 1) ? HW : SW + 1) + 2;

    localparam logic signed [AW-1:0] HP_MAX = {{(AW - HW + 1){1'b0}}, {(HW - 1){1'b1}}};
    localparam logic signed [AW-1:0] HP_MIN = {{(AW - HW + 1){1'b1}}, {(HW - 1){1'b0}}};

    logic signed [SW-1:0] r_lp;
    logic signed [SW-1:0] r_prev;
    logic signed [HW-1:0] r_hp;
    logic signed [SW-1:0] n_lp;
    logic signed [HW-1:0] n_hp;

    logic signed [SW:0]   w_diff;
    logic signed [SW:0]   w_step;
    logic signed [SW:0]   w_delta;
    logic signed [AW-1:0] w_hp_ext;
    logic signed [AW-1:0] w_hp_sum;
    logic signed [HW-1:0] w_hp_neg;

    // Low-pass: the step always lands between the old value and the sample.
    assign w_diff  = (SW + 1)'(i_sample) - (SW + 1)'(r_lp);
    assign w_step  = w_diff >>> LOWPASS_SHIFT;
    assign n_lp    = r_lp + w_step[SW-1:0];
    assign w_delta = (SW + 1)'(n_lp) - (SW + 1)'(r_prev);

    // High-pass leak and update, then clamp to the state width.
    assign w_hp_ext = AW'(r_hp);
    assign w_hp_sum = w_hp_ext - (w_hp_ext >>> HIGHPASS_SHIFT) + AW'(w_delta);

    always_comb begin
        if (w_hp_sum > HP_MAX) begin
            n_hp = HP_MAX[HW-1:0];
        end else if (w_hp_sum < HP_MIN) begin
            n_hp = HP_MIN[HW-1:0];
        end else begin
            n_hp = w_hp_sum[HW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp   <= '0;
            r_prev <= '0;
            r_hp   <= '0;
        end else if (i_en) begin
            r_lp   <= n_lp;
            r_prev <= n_lp;
            r_hp   <= n_hp;
        end
    end

    // The most negative value negates to itself, which read unsigned is its magnitude.
    assign w_hp_neg = -r_hp;
    assign o_abs    = r_hp[HW-1] ? $unsigned(w_hp_neg) : $unsigned(r_hp);

endmodule

[design/tmmf_merge.sv]
module tmmf_merge
    import tmmf_pkg::*;
#(
    parameter int HIGHPASS_WIDTH = HIGHPASS_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_load,
    input  logic [HIGHPASS_WIDTH-1:0] i_abs [NUM_AXES],
    output logic [MAG_WIDTH-1:0]      o_mag
);

    localparam int HW   = HIGHPASS_WIDTH;
    localparam int SUMW = HW + $clog2(NUM_AXES);
    localparam int CW   = (SUMW > MAG_WIDTH + 1) ? SUMW : MAG_WIDTH + 1;

    localparam logic [CW-1:0] MAG_MAX = {{(CW - MAG_WIDTH){1'b0}}, {MAG_WIDTH{1'b1}}};

    logic [CW-1:0]        w_sum;
    logic [MAG_WIDTH-1:0] n_mag;
    logic [MAG_WIDTH-1:0] r_mag;

    always_comb begin
        w_sum = '0;
        for (int k = 0; k < NUM_AXES; k++) begin
            w_sum = w_sum + CW'(i_abs[k]);
        end
        n_mag = (w_sum > MAG_MAX) ? MAG_MAX[MAG_WIDTH-1:0] : w_sum[MAG_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mag <= n_mag;
        end
    end

    assign o_mag = r_mag;

endmodule

[design/triaxial_motion_magnitude_filter_core.sv]
// Channel      Direction  Transaction content
// s_axis       in         one three-axis sample: tdata = accel_x, accel_y, accel_z
// m_axis       out        one magnitude per sample: tdata = magnitude
//
// One sample is taken per cycle when the output side keeps up; each lane's
// low-pass and high-pass recursion closes on its own registers.
// The lanes update their state on the accepting edge, and the merge stage
// registers the saturated L1 sum once the output register is free.
// Reset (i_rst_n low at a clock edge) clears all filter state and empties
// both stages. A stalled output holds its transaction while one more sample
// waits in the lanes; input ready drops only when both are occupied.
module triaxial_motion_magnitude_filter_core
    import tmmf_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int HIGHPASS_WIDTH = HIGHPASS_WIDTH_DEF,
    localparam int IN_DATA_W     = ((NUM_AXES * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // Fields from bit 0 up: accel_x, accel_y, accel_z, zero padding to whole bytes.
    input  logic [IN_DATA_W-1:0] i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // Fields from bit 0 up: magnitude.
    output logic [MAG_WIDTH-1:0] o_m_axis_tdata
);

    logic r_s1_valid;
    logic r_out_valid;
    logic n_s1_valid;
    logic n_out_valid;

    logic w_out_free;
    logic w_accept;
    logic w_load;

    logic [HIGHPASS_WIDTH-1:0] w_abs [NUM_AXES];

    // The output register can take a new value when empty or being drained.
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    // The lanes may update when their last result has been or is being moved on.
    assign o_s_axis_tready = !r_s1_valid || w_out_free;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load          = r_s1_valid && w_out_free;

    assign n_s1_valid  = w_accept || (r_s1_valid && !w_out_free);
    assign n_out_valid = w_load || (r_out_valid && !i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // One lane per axis. The merge stage samples the lanes' high-pass state
    // on the same edge that a new sample may overwrite it, so it always sees
    // the state that belongs to the sample held in the first stage.
    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        tmmf_lane #(
            .SAMPLE_WIDTH  (SAMPLE_WIDTH),
            .HIGHPASS_WIDTH(HIGHPASS_WIDTH)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_accept),
            .i_sample($signed(i_s_axis_tdata[g*SAMPLE_WIDTH +: SAMPLE_WIDTH])),
            .o_abs   (w_abs[g])
        );
    end

    tmmf_merge #(
        .HIGHPASS_WIDTH(HIGHPASS_WIDTH)
    ) u_merge (
        .i_clk (i_clk),
        .i_load(w_load),
        .i_abs (w_abs),
        .o_mag (o_m_axis_tdata)
    );

    assign o_m_axis_tvalid = r_out_valid;

endmodule

[design/tmmf_checker.sv]
module tmmf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_axis_tvalid,
    input logic o_s_axis_tready,
    input logic o_m_axis_tvalid,
    input logic i_m_axis_tready
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output valid dropped while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // Input back-pressure only comes from a full, stalled output.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without a stalled output");

    // A sample taken into an empty output side leads to a valid output after the lane and merge registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && !o_m_axis_tvalid |=> ##1 o_m_axis_tvalid)
        else $error("result missing two cycles after a sample");

endmodule

bind triaxial_motion_magnitude_filter_core tmmf_checker u_tmmf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_s_axis_tvalid(i_s_axis_tvalid),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready)
);
